>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache: request and
// lookup-result structures, request codes and configuration defaults.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // Storage and field widths.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // Value returned by a get that misses.
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // One request as held in the input register.
    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } req_t;

    // Lookup result from the entry store.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } rsp_t;

endpackage

>>> rtl/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Flop-based entry store: parallel key compare over all filled slots, value
// read, and per-slot recency ranks that are updated when a request that hits or stores is processed.
// ----------------------------------------------------------------------------
module lkvc_store #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
    input  logic                        proc_en,
    input  lkvc_pkg::req_t              req,
    output lkvc_pkg::rsp_t              rsp
);

    // Slot index, fill count and wide compare widths.
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::DATA_W-1:0] key_reg  [MAX_ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] val_reg  [MAX_ENTRIES];
    logic [IW-1:0]               rank_reg [MAX_ENTRIES];
    logic [CW-1:0]               fill_reg;
    logic [CW-1:0]               fill_next;

    logic [MAX_ENTRIES-1:0] slot_valid;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] oldest_vec;
    logic [MAX_ENTRIES-1:0] fill_vec;
    logic [MAX_ENTRIES-1:0] target_vec;
    logic [lkvc_pkg::DATA_W-1:0] hit_value;
    logic [IW-1:0]          hit_rank;
    logic                   hit;
    logic [EW-1:0]          cap_ext;
    logic [EW-1:0]          max_ext;
    logic [EW-1:0]          eff_cap;
    logic                   cap_zero;
    logic                   has_room;
    logic                   is_set;
    logic                   do_touch;
    logic                   do_fill;
    logic                   do_evict;
    logic                   do_write;
    logic [CW-1:0]          threshold;
    logic [CW-1:0]          oldest_rank;

    // Capacity saturates at the number of slots.
    always_comb
    begin
        cap_ext  = EW'(capacity);
        max_ext  = EW'(MAX_ENTRIES);
        eff_cap  = (cap_ext > max_ext) ? max_ext : cap_ext;
        cap_zero = (eff_cap == '0);
        has_room = (EW'(fill_reg) < eff_cap);
    end

    // Parallel compare against every filled slot and one-hot value read.
    always_comb
    begin
        oldest_rank = fill_reg - CW'(1);
        hit_value   = '0;
        hit_rank    = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_valid[i] = (CW'(i) < fill_reg);
            match_vec[i]  = slot_valid[i] && (key_reg[i] == req.key);
            oldest_vec[i] = slot_valid[i] && (CW'(rank_reg[i]) == oldest_rank);
            fill_vec[i]   = (CW'(i) == fill_reg);
            if (match_vec[i])
            begin
                hit_value = hit_value | val_reg[i];
                hit_rank  = hit_rank | rank_reg[i];
            end
        end
        hit = |match_vec;
    end

    // Decide what the request does to the store.
    always_comb
    begin
        is_set   = (req.req_type == lkvc_pkg::REQ_SET);
        do_touch = proc_en && hit && (!is_set || !cap_zero);
        do_fill  = proc_en && is_set && !cap_zero && !hit && has_room;
        do_evict = proc_en && is_set && !cap_zero && !hit && !has_room;
        do_write = do_touch || do_fill || do_evict;

        if (hit)
        begin
            target_vec = match_vec;
            threshold  = CW'(hit_rank);
        end
        else if (has_room)
        begin
            target_vec = fill_vec;
            threshold  = fill_reg;
        end
        else
        begin
            target_vec = oldest_vec;
            threshold  = oldest_rank;
        end

        fill_next = do_fill ? (fill_reg + CW'(1)) : fill_reg;
    end

    // Entry payload and recency ranks. Rank zero is the newest slot; every
    // filled slot newer than the target moves one place older.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (target_vec[i])
                begin
                    rank_reg[i] <= '0;
                    if (is_set)
                    begin
                        key_reg[i] <= req.key;
                        val_reg[i] <= req.value;
                    end
                end
                else if (slot_valid[i] && (CW'(rank_reg[i]) < threshold))
                begin
                    rank_reg[i] <= rank_reg[i] + IW'(1);
                end
            end
        end
    end

    // Fill count: slots below it hold live entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign rsp.hit   = hit;
    assign rsp.value = hit ? hit_value : lkvc_pkg::MISS_VALUE;

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// A get result passes the input register, then the result register, and is
// held longer only while the result side stalls. Throughput: one request
// per cycle unless a get waits on a stalled result side; the combinational
// lookup and registered update of the flop-based store set this. Reset
// empties the store at once (fill count cleared) and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wr_data,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [lkvc_pkg::DATA_W-1:0]   lookup_key,
    input  logic [lkvc_pkg::DATA_W-1:0]   store_value,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [lkvc_pkg::DATA_W-1:0]   read_value
);

    logic [lkvc_pkg::CAP_W-1:0]  capacity_reg;
    logic                        inbuf_valid_reg;
    logic                        inbuf_valid_next;
    lkvc_pkg::req_t              inbuf_reg;
    lkvc_pkg::rsp_t              rsp;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        found_reg;
    logic [lkvc_pkg::DATA_W-1:0] value_reg;
    logic                        out_free;
    logic                        proc_en;
    logic                        in_take;
    logic                        emit;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Handshake control. A set produces no result, so only a get waits for
    // room in the result register.
    always_comb
    begin
        out_free         = !out_valid_reg || !out_stall;
        proc_en          = inbuf_valid_reg &&
                           ((inbuf_reg.req_type == lkvc_pkg::REQ_SET) || out_free);
        in_stall         = inbuf_valid_reg && !proc_en;
        in_take          = in_valid && !in_stall;
        emit             = proc_en && (inbuf_reg.req_type == lkvc_pkg::REQ_GET);
        inbuf_valid_next = in_take || (inbuf_valid_reg && !proc_en);
        out_valid_next   = emit || (out_valid_reg && out_stall);
    end

    // Input register valid flag and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inbuf_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            inbuf_valid_reg <= inbuf_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            inbuf_reg.req_type <= req_type;
            inbuf_reg.key      <= lookup_key;
            inbuf_reg.value    <= store_value;
        end
    end

    // Entry store with lookup and recency update.
    lkvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .proc_en  (proc_en),
        .req      (inbuf_reg),
        .rsp      (rsp)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg <= rsp.hit;
            value_reg <= rsp.value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = value_reg;

endmodule
